FILE: rtl/ptp_pkg.sv
// Package for the peak-to-peak tracker: sizing constants and the request and result types.
// Depends on nothing; the tracker module imports it.
package ptp_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int RANK_DEPTH = 5;
	localparam int SUM_BITS = SAMPLE_BITS + 1;
	localparam int CNT_BITS = $clog2(RANK_DEPTH + 1);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   last;
	} ptp_req_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] peak_sum;
		logic [SUM_BITS-1:0] trough_sum;
		logic [SUM_BITS-1:0] span_doubled;
		logic                enough;
	} ptp_res_t;

endpackage

FILE: rtl/top5_peak_to_peak_tracker.sv
// Top level of the peak-to-peak tracker: ranked lists of the largest and smallest samples.
// Depends on ptp_pkg for sizes and the request and result types.
// The block takes one request per clock cycle unless the request side stalls. A request is
// held in an input register, then ranked into both lists by a parallel compare across all
// slots. A request marked last produces one result, registered when it leaves the input
// register, and the lists clear in the same cycle. Stall on the request side rises only when
// a last request sits in the input register while the previous result is still held by a
// stall on the result side; non-last requests always pass, even while a result waits.
module top5_peak_to_peak_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ptp_pkg::ptp_req_t req,
	output logic              result_valid,
	input  logic              result_stall,
	output ptp_pkg::ptp_res_t result
);
	import ptp_pkg::*;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   last_s1;
	logic                   advance;

	logic [SAMPLE_BITS-1:0] top_q [RANK_DEPTH];
	logic [SAMPLE_BITS-1:0] bottom_q [RANK_DEPTH];
	logic [CNT_BITS-1:0]    cnt_q;

	logic [SAMPLE_BITS-1:0] top_nxt [RANK_DEPTH];
	logic [SAMPLE_BITS-1:0] bottom_nxt [RANK_DEPTH];
	logic [RANK_DEPTH-1:0]  top_beat;
	logic [RANK_DEPTH-1:0]  bottom_beat;
	logic [CNT_BITS-1:0]    cnt_nxt;

	logic [SUM_BITS-1:0] peak;
	logic [SUM_BITS-1:0] trough;
	ptp_res_t            res_nxt;

	logic     result_valid_q;
	ptp_res_t result_q;

	assign advance = valid_s1 && (!last_s1 || !result_valid_q || !result_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			sample_s1 <= req.sample;
			last_s1 <= req.last;
		end
	end

	// Slots at or beyond the fill count are empty and take any sample.
	always_comb begin
		for (int k = 0; k < RANK_DEPTH; k++) begin
			top_beat[k] = (CNT_BITS'(k) >= cnt_q) || (sample_s1 > top_q[k]);
			bottom_beat[k] = (CNT_BITS'(k) >= cnt_q) || (sample_s1 < bottom_q[k]);
		end
		top_nxt[0] = top_beat[0] ? sample_s1 : top_q[0];
		bottom_nxt[0] = bottom_beat[0] ? sample_s1 : bottom_q[0];
		for (int k = 1; k < RANK_DEPTH; k++) begin
			if (!top_beat[k]) begin
				top_nxt[k] = top_q[k];
			end else if (top_beat[k-1]) begin
				top_nxt[k] = top_q[k-1];
			end else begin
				top_nxt[k] = sample_s1;
			end
			if (!bottom_beat[k]) begin
				bottom_nxt[k] = bottom_q[k];
			end else if (bottom_beat[k-1]) begin
				bottom_nxt[k] = bottom_q[k-1];
			end else begin
				bottom_nxt[k] = sample_s1;
			end
		end
		cnt_nxt = (cnt_q == CNT_BITS'(RANK_DEPTH)) ? cnt_q : cnt_q + CNT_BITS'(1);
	end

	always_comb begin
		peak = {1'b0, top_nxt[0]} + {1'b0, top_nxt[RANK_DEPTH-1]};
		trough = {1'b0, bottom_nxt[0]} + {1'b0, bottom_nxt[RANK_DEPTH-1]};
		res_nxt = '0;
		if (cnt_nxt == CNT_BITS'(RANK_DEPTH)) begin
			res_nxt.peak_sum = peak;
			res_nxt.trough_sum = trough;
			res_nxt.span_doubled = (peak >= trough) ? peak - trough : '0;
			res_nxt.enough = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= last_s1 ? '0 : cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			top_q <= top_nxt;
			bottom_q <= bottom_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	// The request side stalls only behind a held result with a last request waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && last_s1 && result_valid_q && result_stall))
		else $error("request stall without a held result");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(RANK_DEPTH))
		else $error("fill count beyond list depth");

	// A last request empties both lists in the following cycle.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (cnt_q == '0 && result_valid_q))
		else $error("lists not cleared after the last request");

	a_short_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.enough) |->
		(result_q.peak_sum == '0 && result_q.trough_sum == '0 && result_q.span_doubled == '0))
		else $error("short block result not zero");

	a_lists_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CNT_BITS'(RANK_DEPTH)) |->
		(top_q[0] >= top_q[RANK_DEPTH-1] && bottom_q[0] <= bottom_q[RANK_DEPTH-1]))
		else $error("ranked lists out of order");
`endif

endmodule
